// ===== design/hvl_pkg.sv =====
package hvl_pkg;

	localparam int CORDIC_STEPS_DEF = 32;
	localparam int TOTAL_BITS_DEF   = 48;

	// datapath widths
	localparam int CORD_W = 36;
	localparam int MUL_W  = 34;
	localparam int PROD_W = 2 * MUL_W;
	localparam int SQ_W   = 63;
	localparam int SQ_IN_W = 61;

	localparam logic signed [MUL_W-1:0]  RAD_K        = 34'sd8048910509;
	localparam logic signed [MUL_W-1:0]  MM_PER_M     = 34'sd1000;
	localparam logic signed [CORD_W-1:0] CORDIC_GAIN  = 36'sd652032874;
	localparam logic [30:0]              HALF_PI_Q30  = 31'd1686629713;
	localparam logic [30:0]              ONE_Q30      = 31'd1073741824;
	localparam logic signed [33:0]       HALF_TURN    = 34'sd1800000000;
	localparam logic signed [33:0]       FULL_TURN    = 34'sd3600000000;
	localparam logic [30:0]              QUARTER_TURN = 31'd900000000;
	localparam logic [30:0]              HALF_TURN_U  = 31'd1800000000;
	localparam logic [22:0]              RADIUS_RESET = 23'd6371000;

	typedef struct packed {
		logic signed [30:0] latitude;
		logic signed [31:0] longitude;
		logic               track_start;
	} hvl_in_t;

	typedef struct packed {
		logic [34:0] segment_mm;
		logic [47:0] total_mm;
		logic        total_saturated;
	} hvl_out_t;

	typedef struct packed {
		logic start;
		logic vec;
	} hvl_cordic_cmd_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_ANG,
		ST_ROT_GO,
		ST_ROT_WAIT,
		ST_M_SL,
		ST_M_CC,
		ST_M_SN,
		ST_M_X,
		ST_M_A,
		ST_SQP_WAIT,
		ST_SQQ_GO,
		ST_SQQ_WAIT,
		ST_VEC_WAIT,
		ST_M_R,
		ST_M_Z,
		ST_M_SEG,
		ST_DONE
	} hvl_state_t;

	// arctan(2^-i) in q2.30
	function automatic logic [31:0] hvl_atan(input logic [5:0] i);
		logic [31:0] r;
		r = '0;
		if (i < 6'd11) begin
			unique case (i)
				6'd0:    r = 32'd843314857;
				6'd1:    r = 32'd497837829;
				6'd2:    r = 32'd263043837;
				6'd3:    r = 32'd133525159;
				6'd4:    r = 32'd67021687;
				6'd5:    r = 32'd33543516;
				6'd6:    r = 32'd16775851;
				6'd7:    r = 32'd8388437;
				6'd8:    r = 32'd4194283;
				6'd9:    r = 32'd2097149;
				default: r = 32'd1048576;
			endcase
		end else if (i <= 6'd30) begin
			r = 32'd1 << 5'(6'd30 - i);
		end
		return r;
	endfunction

	// wrap a difference into half a turn either side and take its magnitude
	function automatic logic [30:0] hvl_wrap_mag(input logic signed [33:0] d);
		logic signed [33:0] r;
		r = d;
		if (d >= HALF_TURN) begin
			r = d - FULL_TURN;
		end else if (d < -HALF_TURN) begin
			r = d + FULL_TURN;
		end
		return r[33] ? 31'(-r) : 31'(r);
	endfunction

	// latitude magnitude folded into the first quadrant, msb flags negated cosine
	function automatic logic [31:0] hvl_cos_mag(input logic signed [30:0] l);
		logic [30:0] a;
		logic        neg;
		a   = l[30] ? 31'(-l) : 31'(l);
		neg = 1'b0;
		if (a > QUARTER_TURN) begin
			a   = HALF_TURN_U - a;
			neg = 1'b1;
		end
		return {neg, a};
	endfunction

endpackage

// ===== design/hvl_cordic.sv =====
module hvl_cordic import hvl_pkg::*; #(
	parameter int STEPS = CORDIC_STEPS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  hvl_cordic_cmd_t          cmd,
	input  logic signed [CORD_W-1:0] x0,
	input  logic signed [CORD_W-1:0] y0,
	input  logic signed [CORD_W-1:0] z0,
	output logic                     done,
	output logic signed [CORD_W-1:0] x,
	output logic signed [CORD_W-1:0] y,
	output logic signed [CORD_W-1:0] z
);

	localparam int IW = $clog2(STEPS);

	logic [IW-1:0]            i_q;
	logic                     busy_q;
	logic                     done_q;
	logic                     vec_q;
	logic signed [CORD_W-1:0] x_q, y_q, z_q;
	logic signed [CORD_W-1:0] xs, ys, t, nx, ny, nz;
	logic                     pos;

	always_comb begin
		xs  = x_q >>> i_q;
		ys  = y_q >>> i_q;
		t   = signed'(CORD_W'(hvl_atan(6'(i_q))));
		// rotation steers on z, vectoring on y
		pos = vec_q ? y_q[CORD_W-1] : !z_q[CORD_W-1];
		nx  = pos ? x_q - ys : x_q + ys;
		ny  = pos ? y_q + xs : y_q - xs;
		nz  = pos ? z_q - t : z_q + t;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			i_q    <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
			vec_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (cmd.start) begin
				i_q    <= '0;
				busy_q <= 1'b1;
				vec_q  <= cmd.vec;
			end else if (busy_q) begin
				i_q <= i_q + 1'b1;
				if (i_q == IW'(STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			x_q <= x0;
			y_q <= y0;
			z_q <= z0;
		end else if (busy_q) begin
			x_q <= nx;
			y_q <= ny;
			z_q <= nz;
		end
	end

	assign done = done_q;
	assign x    = x_q;
	assign y    = y_q;
	assign z    = z_q;

endmodule

// ===== design/hvl_isqrt.sv =====
module hvl_isqrt import hvl_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [SQ_IN_W-1:0] n_in,
	output logic               done,
	output logic [30:0]        root
);

	logic [SQ_W-1:0] n_q, res_q, bit_q;
	logic [SQ_W-1:0] trial;
	logic            busy_q;
	logic            done_q;
	logic            ge;

	assign trial = res_q + bit_q;
	assign ge    = n_q >= trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
			end else if (busy_q && bit_q[0]) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	// one result bit per cycle, bit walks down two places at a time
	always_ff @(posedge clk) begin
		if (start) begin
			n_q   <= SQ_W'(n_in);
			res_q <= '0;
			bit_q <= SQ_W'(1) << (SQ_W - 1);
		end else if (busy_q) begin
			if (ge) begin
				n_q   <= n_q - trial;
				res_q <= (res_q >> 1) + bit_q;
			end else begin
				res_q <= res_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
	end

	assign done = done_q;
	assign root = res_q[30:0];

endmodule

// ===== design/track_haversine_length.sv =====
// track length accumulator, spherical haversine distance between track points
//
// input channel in_valid/in_ready/in_data carries one point per transaction:
// latitude and longitude in 1e-7 degree and a track_start flag. each accepted
// point gives exactly one transaction on out_valid/out_ready/out_data with the
// segment length to the previous point and the running total, both in mm.
// cfg_wr_en/cfg_wr_data write the earth radius in metres; write it only
// while the block is idle.
// a point that starts a track (or the first point after reset) skips the
// distance work and goes straight to the result. any other point takes four
// cordic rotations and one vectoring pass on the shared cordic unit, two
// 32-step square roots and ten passes through the shared multiplier. in_ready
// is high only while the sequencer is idle.
// the result sits in an output register; a stalled receiver holds it there
// while the next point is already accepted and worked on, and a second
// result waits in the sequencer until the register frees up.
// reset clears the previous point and the total and sets the radius to 6371000 m.
module track_haversine_length import hvl_pkg::*; #(
	parameter int CORDIC_STEPS = CORDIC_STEPS_DEF,
	parameter int TOTAL_BITS   = TOTAL_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [22:0] cfg_wr_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  hvl_in_t     in_data,
	output logic        out_valid,
	input  logic        out_ready,
	output hvl_out_t    out_data
);

	localparam logic [TOTAL_BITS-1:0] TOTAL_MAX = {TOTAL_BITS{1'b1}};

	hvl_state_t state_q, state_d;

	// configuration and per-track state
	logic [22:0]              radius_q;
	logic signed [30:0]       prev_lat_q;
	logic signed [31:0]       prev_lon_q;
	logic                     have_prev_q;
	logic [TOTAL_BITS-1:0]    total_q;

	// working registers
	logic [30:0]              mag_q [4];
	logic [1:0]               cneg_q;
	logic [1:0]               j_q;
	logic signed [MUL_W-1:0]  sl_q, sn_q, c1_q, c2_q, t1_q, cc_q;
	logic [30:0]              a_q, p_q, zc_q;
	logic [34:0]              seg_q;
	logic signed [PROD_W-1:0] prod_q;

	logic                     out_valid_q;
	hvl_out_t                 out_q;

	// shared multiplier operands
	logic signed [MUL_W-1:0]  mul_a, mul_b;
	logic signed [PROD_W-1:0] prod_d;
	logic signed [MUL_W-1:0]  prod_sh;

	// cordic and square root hookup
	hvl_cordic_cmd_t          cor_cmd;
	logic signed [CORD_W-1:0] cor_x0, cor_y0, cor_z0;
	logic signed [CORD_W-1:0] cor_x, cor_y, cor_z;
	logic                     cor_done;
	logic                     sq_start;
	logic [SQ_IN_W-1:0]       sq_n;
	logic                     sq_done;
	logic [30:0]              sq_root;

	logic                     acc;
	logic                     first_pt;
	logic                     out_free;
	logic [31:0]              cm1, cm2;
	logic [PROD_W-1:0]        rnd_ang;
	logic signed [CORD_W-1:0] a_sum;
	logic [30:0]              a_clamp;
	logic [30:0]              z_clamp;
	logic [PROD_W-1:0]        rnd_seg;
	logic [TOTAL_BITS:0]      tot_sum;

	assign acc      = in_valid && in_ready;
	assign first_pt = in_data.track_start || !have_prev_q;
	assign out_free = !out_valid_q || out_ready;
	assign cm1      = hvl_cos_mag(prev_lat_q);
	assign cm2      = hvl_cos_mag(in_data.latitude);
	assign prod_d   = mul_a * mul_b;
	assign prod_sh  = MUL_W'(prod_q >>> 30);

	// half angles round at bit 33, full latitude angles at bit 32
	always_comb begin
		if (!j_q[1]) begin
			rnd_ang = (PROD_W'(prod_q) + (PROD_W'(1) << 32)) >> 33;
		end else begin
			rnd_ang = (PROD_W'(prod_q) + (PROD_W'(1) << 31)) >> 32;
		end
	end

	always_comb begin
		a_sum = CORD_W'(t1_q) + CORD_W'(prod_sh);
		if (a_sum[CORD_W-1]) begin
			a_clamp = '0;
		end else if (a_sum > CORD_W'(ONE_Q30)) begin
			a_clamp = ONE_Q30;
		end else begin
			a_clamp = a_sum[30:0];
		end
	end

	always_comb begin
		if (cor_z[CORD_W-1]) begin
			z_clamp = '0;
		end else if (cor_z > CORD_W'(HALF_PI_Q30)) begin
			z_clamp = HALF_PI_Q30;
		end else begin
			z_clamp = cor_z[30:0];
		end
	end

	assign rnd_seg = (PROD_W'(prod_q) + (PROD_W'(1) << 28)) >> 29;
	assign tot_sum = (TOTAL_BITS+1)'(total_q) + (TOTAL_BITS+1)'(rnd_seg[34:0]);

	// sequencer: next state and unit controls
	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		mul_a    = '0;
		mul_b    = '0;
		cor_cmd  = '0;
		cor_x0   = CORDIC_GAIN;
		cor_y0   = '0;
		cor_z0   = CORD_W'(rnd_ang);
		sq_start = 1'b0;
		sq_n     = {a_clamp, 30'd0};
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					state_d = first_pt ? ST_DONE : ST_ANG;
				end
			end
			ST_ANG: begin
				// degrees*1e-7 to radians
				mul_a   = MUL_W'(mag_q[j_q]);
				mul_b   = RAD_K;
				state_d = ST_ROT_GO;
			end
			ST_ROT_GO: begin
				cor_cmd.start = 1'b1;
				state_d       = ST_ROT_WAIT;
			end
			ST_ROT_WAIT: begin
				if (cor_done) begin
					state_d = (j_q == 2'd3) ? ST_M_SL : ST_ANG;
				end
			end
			ST_M_SL: begin
				mul_a   = sl_q;
				mul_b   = sl_q;
				state_d = ST_M_CC;
			end
			ST_M_CC: begin
				mul_a   = c1_q;
				mul_b   = c2_q;
				state_d = ST_M_SN;
			end
			ST_M_SN: begin
				mul_a   = sn_q;
				mul_b   = sn_q;
				state_d = ST_M_X;
			end
			ST_M_X: begin
				mul_a   = cc_q;
				mul_b   = prod_sh;
				state_d = ST_M_A;
			end
			ST_M_A: begin
				sq_start = 1'b1;
				state_d  = ST_SQP_WAIT;
			end
			ST_SQP_WAIT: begin
				if (sq_done) begin
					state_d = ST_SQQ_GO;
				end
			end
			ST_SQQ_GO: begin
				sq_start = 1'b1;
				sq_n     = {ONE_Q30 - a_q, 30'd0};
				state_d  = ST_SQQ_WAIT;
			end
			ST_SQQ_WAIT: begin
				// central angle from atan2(sqrt(a), sqrt(1-a))
				cor_x0  = CORD_W'(sq_root);
				cor_y0  = CORD_W'(p_q);
				cor_z0  = '0;
				if (sq_done) begin
					cor_cmd.start = 1'b1;
					cor_cmd.vec   = 1'b1;
					state_d       = ST_VEC_WAIT;
				end
			end
			ST_VEC_WAIT: begin
				if (cor_done) begin
					state_d = ST_M_R;
				end
			end
			ST_M_R: begin
				mul_a   = MUL_W'(radius_q);
				mul_b   = MM_PER_M;
				state_d = ST_M_Z;
			end
			ST_M_Z: begin
				mul_a   = prod_q[MUL_W-1:0];
				mul_b   = MUL_W'(zc_q);
				state_d = ST_M_SEG;
			end
			ST_M_SEG: begin
				state_d = ST_DONE;
			end
			ST_DONE: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// control and architectural state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q    <= RADIUS_RESET;
			prev_lat_q  <= '0;
			prev_lon_q  <= '0;
			have_prev_q <= 1'b0;
			total_q     <= '0;
			j_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				radius_q <= cfg_wr_data;
			end
			if (acc) begin
				prev_lat_q  <= in_data.latitude;
				prev_lon_q  <= in_data.longitude;
				have_prev_q <= 1'b1;
				j_q         <= '0;
				if (first_pt) begin
					total_q <= '0;
				end
			end
			if (state_q == ST_ROT_WAIT && cor_done) begin
				j_q <= j_q + 2'd1;
			end
			if (state_q == ST_M_SEG) begin
				// saturating add, sticks until the next track start
				if (tot_sum > (TOTAL_BITS+1)'(TOTAL_MAX)) begin
					total_q <= TOTAL_MAX;
				end else begin
					total_q <= tot_sum[TOTAL_BITS-1:0];
				end
			end
			if (state_q == ST_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		prod_q <= prod_d;
		if (acc) begin
			mag_q[0] <= hvl_wrap_mag(34'(in_data.latitude) - 34'(prev_lat_q));
			mag_q[1] <= hvl_wrap_mag(34'(in_data.longitude) - 34'(prev_lon_q));
			mag_q[2] <= cm1[30:0];
			mag_q[3] <= cm2[30:0];
			cneg_q   <= {cm2[31], cm1[31]};
			seg_q    <= '0;
		end
		if (state_q == ST_ROT_WAIT && cor_done) begin
			unique case (j_q)
				2'd0: sl_q <= cor_y[MUL_W-1:0];
				2'd1: sn_q <= cor_y[MUL_W-1:0];
				2'd2: c1_q <= cneg_q[0] ? -cor_x[MUL_W-1:0] : cor_x[MUL_W-1:0];
				default: c2_q <= cneg_q[1] ? -cor_x[MUL_W-1:0] : cor_x[MUL_W-1:0];
			endcase
		end
		if (state_q == ST_M_CC) begin
			t1_q <= prod_sh;
		end
		if (state_q == ST_M_SN) begin
			cc_q <= prod_sh;
		end
		if (state_q == ST_M_A) begin
			a_q <= a_clamp;
		end
		if (state_q == ST_SQP_WAIT && sq_done) begin
			p_q <= sq_root;
		end
		if (state_q == ST_VEC_WAIT && cor_done) begin
			zc_q <= z_clamp;
		end
		if (state_q == ST_M_SEG) begin
			seg_q <= rnd_seg[34:0];
		end
		if (state_q == ST_DONE && out_free) begin
			out_q.segment_mm      <= seg_q;
			out_q.total_mm        <= 48'(total_q);
			out_q.total_saturated <= (total_q == TOTAL_MAX);
		end
	end

	hvl_cordic #(
		.STEPS(CORDIC_STEPS)
	) u_cordic (
		.clk   (clk),
		.arst_n(arst_n),
		.cmd   (cor_cmd),
		.x0    (cor_x0),
		.y0    (cor_y0),
		.z0    (cor_z0),
		.done  (cor_done),
		.x     (cor_x),
		.y     (cor_y),
		.z     (cor_z)
	);

	hvl_isqrt u_isqrt (
		.clk   (clk),
		.arst_n(arst_n),
		.start (sq_start),
		.n_in  (sq_n),
		.done  (sq_done),
		.root  (sq_root)
	);

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	a_cordic_done_owned: assert property (@(posedge clk) disable iff (!arst_n)
		cor_done |-> (state_q == ST_ROT_WAIT || state_q == ST_VEC_WAIT))
		else $error("cordic finished outside a wait state");

	a_sqrt_done_owned: assert property (@(posedge clk) disable iff (!arst_n)
		sq_done |-> (state_q == ST_SQP_WAIT || state_q == ST_SQQ_WAIT))
		else $error("square root finished outside a wait state");

	a_start_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && in_data.track_start) |=> (seg_q == '0 && total_q == '0))
		else $error("track start did not clear segment and total");

	a_total_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_M_SEG) |=> (total_q >= $past(total_q)))
		else $error("running total decreased within a track");

endmodule

// ===== sim/track_haversine_checker.sv =====
module track_haversine_checker import hvl_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     cfg_wr_en,
	input  logic [22:0] cfg_wr_data,
	input  logic     in_valid,
	input  logic     in_ready,
	input  hvl_in_t  in_data,
	input  logic     out_valid,
	input  logic     out_ready,
	input  hvl_out_t out_data,
	output int       mismatches,
	output int       pending
);

	localparam longint TURN      = 64'sd3600000000;
	localparam longint HALF      = 64'sd1800000000;
	localparam longint QUARTER   = 64'sd900000000;
	localparam longint UNIT_Q30  = 64'sd1073741824;
	localparam longint RIGHT_Q30 = 64'sd1686629713;
	localparam bit [63:0] DEG_TO_RAD = 64'd8048910509;
	localparam bit [63:0] TOTAL_MAX  = 64'hFFFF_FFFF_FFFF;

	hvl_out_t       expected_q[$];
	longint         last_lat, last_lon;
	bit             has_last;
	bit [63:0]      track_total;
	bit [63:0]      radius_m;

	function automatic longint atan_step(int i);
		longint lut[11] = '{843314857, 497837829, 263043837, 133525159, 67021687,
			33543516, 16775851, 8388437, 4194283, 2097149, 1048576};
		if (i < 11)
			return lut[i];
		if (i <= 30)
			return 64'sd1 << (30 - i);
		return 0;
	endfunction

	function automatic longint fold_turn(longint d);
		longint r;
		r = d % TURN;
		if (r < -HALF)
			r += TURN;
		if (r >= HALF)
			r -= TURN;
		return r;
	endfunction

	function automatic void rotate_q30(longint ang, output longint s, output longint c);
		longint x, y, z, dx, dy;
		x = 652032874;
		y = 0;
		z = ang;
		for (int i = 0; i < CORDIC_STEPS_DEF; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (z >= 0) begin
				x -= dx; y += dy; z -= atan_step(i);
			end else begin
				x += dx; y -= dy; z += atan_step(i);
			end
		end
		s = y;
		c = x;
	endfunction

	function automatic longint sin_half(longint d);
		longint r, s, c;
		bit [63:0] m;
		r = fold_turn(d);
		m = (r < 0) ? -r : r;
		rotate_q30(longint'((m * DEG_TO_RAD + (64'd1 << 32)) >> 33), s, c);
		return s;
	endfunction

	function automatic longint cos_lat(longint lat);
		longint r, s, c;
		bit [63:0] m;
		bit neg;
		r = fold_turn(lat);
		m = (r < 0) ? -r : r;
		neg = 0;
		if (m > QUARTER) begin
			m = HALF - m;
			neg = 1;
		end
		rotate_q30(longint'((m * DEG_TO_RAD + (64'd1 << 31)) >> 32), s, c);
		return neg ? -c : c;
	endfunction

	function automatic bit [63:0] int_sqrt(bit [63:0] n);
		bit [63:0] res, b;
		res = 0;
		b = 64'd1 << 62;
		while (b > n)
			b >>= 2;
		while (b != 0) begin
			if (n >= res + b) begin
				n -= res + b;
				res = (res >> 1) + b;
			end else begin
				res >>= 1;
			end
			b >>= 2;
		end
		return res;
	endfunction

	function automatic bit [63:0] great_circle_mm(longint lat1, longint lon1,
			longint lat2, longint lon2);
		longint sl, sn, c1, c2, a, x, y, z, dx, dy;
		sl = sin_half(lat2 - lat1);
		sn = sin_half(lon2 - lon1);
		c1 = cos_lat(lat1);
		c2 = cos_lat(lat2);
		a = ((sl * sl) >>> 30) + ((((c1 * c2) >>> 30) * ((sn * sn) >>> 30)) >>> 30);
		if (a < 0)
			a = 0;
		if (a > UNIT_Q30)
			a = UNIT_Q30;
		y = int_sqrt(a << 30);
		x = int_sqrt((UNIT_Q30 - a) << 30);
		z = 0;
		for (int i = 0; i < CORDIC_STEPS_DEF; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (y >= 0) begin
				x += dx; y -= dy; z += atan_step(i);
			end else begin
				x -= dx; y += dy; z -= atan_step(i);
			end
		end
		if (z < 0)
			z = 0;
		if (z > RIGHT_Q30)
			z = RIGHT_Q30;
		return (radius_m * 1000 * bit'(1) * z + (64'd1 << 28)) >> 29;
	endfunction

	function automatic hvl_out_t next_point(hvl_in_t p);
		hvl_out_t r;
		bit [63:0] seg;
		longint lat, lon;
		lat = p.latitude;
		lon = p.longitude;
		seg = 0;
		if (p.track_start || !has_last) begin
			track_total = 0;
		end else begin
			seg = great_circle_mm(last_lat, last_lon, lat, lon);
			if (seg > TOTAL_MAX - track_total)
				track_total = TOTAL_MAX;
			else
				track_total += seg;
		end
		last_lat = lat;
		last_lon = lon;
		has_last = 1;
		r.segment_mm = seg[34:0];
		r.total_mm = track_total[47:0];
		r.total_saturated = (track_total == TOTAL_MAX);
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		hvl_out_t e;
		if (!arst_n) begin
			expected_q.delete();
			last_lat = 0;
			last_lon = 0;
			has_last = 0;
			track_total = 0;
			radius_m = 6371000;
			mismatches = 0;
		end else begin
			if (cfg_wr_en)
				radius_m = cfg_wr_data;
			if (in_valid && in_ready)
				expected_q.push_back(next_point(in_data));
			if (out_valid && out_ready) begin
				if (expected_q.size() == 0) begin
					if (mismatches < 10)
						$display("unexpected result transaction: %p", out_data);
					mismatches++;
				end else begin
					e = expected_q.pop_front();
					if (e !== out_data) begin
						if (mismatches < 10)
							$display("result differs: expected seg=%0d total=%0d sat=%0d, got seg=%0d total=%0d sat=%0d",
								e.segment_mm, e.total_mm, e.total_saturated,
								out_data.segment_mm, out_data.total_mm,
								out_data.total_saturated);
						mismatches++;
					end
				end
			end
		end
		pending = expected_q.size();
	end

endmodule

// ===== sim/testbench.sv =====
module testbench;
	import hvl_pkg::*;

	logic     clk = 0;
	logic     arst_n = 0;
	logic     cfg_wr_en = 0;
	logic [22:0] cfg_wr_data = '0;
	logic     in_valid = 0;
	logic     in_ready;
	hvl_in_t  in_data = '0;
	logic     out_valid;
	logic     out_ready = 0;
	hvl_out_t out_data;
	int       mismatches;
	int       pending;

	// receiver control: a long hold-off is requested by the stimulus, counted here
	bit       hold_request = 0;
	bit       hold_seen = 0;
	int       hold_left = 0;
	int       ready_mode = 0;
	int       mode_left = 0;

	always #1 clk = ~clk;

	track_haversine_length dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
	);

	track_haversine_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.mismatches(mismatches), .pending(pending)
	);

	// receiver stall pattern: modes switch every so often, long hold-off on request
	always @(posedge clk) begin
		if (!arst_n) begin
			out_ready <= 0;
		end else if (hold_request && !hold_seen) begin
			hold_seen = 1;
			hold_left = 1500;
			out_ready <= 0;
		end else if (hold_left > 0) begin
			hold_left--;
			out_ready <= 0;
		end else begin
			if (mode_left == 0) begin
				ready_mode = $urandom_range(0, 2);
				mode_left = $urandom_range(50, 600);
			end
			mode_left--;
			case (ready_mode)
				0: out_ready <= 1;
				1: out_ready <= $urandom_range(0, 1);
				default: out_ready <= ($urandom_range(0, 7) == 0);
			endcase
		end
	end

	// sender gap control
	bit       bursty = 1;
	int       burst_left = 0;

	// one point transaction, held until accepted; valid stays up inside a burst
	task automatic send_point(input logic signed [30:0] lat, input logic signed [31:0] lon,
			input logic start);
		int gap;
		if (bursty && burst_left == 0) begin
			burst_left = $urandom_range(1, 12);
			gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 400);
			if (gap > 0) begin
				in_valid <= 0;
				repeat (gap) @(posedge clk);
			end
		end
		if (burst_left > 0)
			burst_left--;
		in_valid <= 1;
		in_data <= '{latitude: lat, longitude: lon, track_start: start};
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
	endtask

	task automatic drain;
		in_valid <= 0;
		@(negedge clk);
		while (pending != 0)
			@(negedge clk);
		repeat (10) @(posedge clk);
	endtask

	task automatic set_radius(input logic [22:0] r);
		drain();
		cfg_wr_en <= 1;
		cfg_wr_data <= r;
		@(posedge clk);
		cfg_wr_en <= 0;
	endtask

	// random track segment: mostly nearby points along a track, some wild jumps
	task automatic random_points(input int n);
		logic signed [30:0] lat;
		logic signed [31:0] lon;
		lat = 31'($urandom_range(0, 1800000000) - 900000000);
		lon = $urandom();
		for (int k = 0; k < n; k++) begin
			case ($urandom_range(0, 9))
				0: begin
					lat = 31'($urandom());
					lon = $urandom();
				end
				1, 2: begin
					lat = 31'($urandom_range(0, 1800000000) - 900000000);
					lon = $urandom_range(0, 3600000000) - 1800000000;
				end
				default: begin
					lat = 31'(lat + $signed($urandom_range(0, 200000)) - 100000);
					lon = lon + $signed($urandom_range(0, 200000)) - 100000;
				end
			endcase
			send_point(lat, lon, $urandom_range(0, 19) == 0);
		end
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: first point after reset, zero distance, extremes, wrap, antipodes
		send_point(31'sd0, 32'sd0, 0);
		send_point(31'sd0, 32'sd0, 0);
		send_point(31'sd900000000, 32'sd1800000000, 0);
		send_point(-31'sd900000000, -32'sd1800000000, 0);
		send_point(31'sd0, 32'sd1800000000, 1);
		send_point(31'sd0, 32'sd0, 0);
		send_point(31'sh3FFF_FFFF, 32'sh7FFF_FFFF, 0);
		send_point(31'sh4000_0000, 32'sh8000_0000, 0);
		send_point(31'sd1000000000, -32'sd1799999999, 0);
		send_point(-31'sd1000000000, 32'sd1799999999, 0);
		send_point(31'sd450000000, 32'sd10, 1);
		send_point(-31'sd450000000, 32'sd1800000010, 0);
		send_point(31'sd899999999, 32'sd5, 0);
		send_point(31'sd899999999, -32'sd1799999995, 0);
		send_point(31'sd1, 32'sd1, 0);

		// radius extremes, including values outside the nominal range
		set_radius(23'd6000000);
		random_points(30);
		set_radius(23'd7000000);
		random_points(30);
		set_radius(23'd0);
		random_points(20);
		set_radius(23'h7FFFFF);

		// long receiver hold-off while points keep coming
		bursty = 0;
		hold_request = 1;
		random_points(20);
		bursty = 1;

		// drain, then long random runs with a new radius in between
		drain();
		random_points(400);
		set_radius(23'($urandom_range(6000000, 7000000)));
		random_points(300);

		// large totals: antipodal hops at the largest radius, then restart
		set_radius(23'h7FFFFF);
		bursty = 0;
		send_point(31'sd0, 32'sd0, 1);
		for (int k = 0; k < 200; k++)
			send_point(31'sd0, (k % 2 == 0) ? 32'sd1800000000 : 32'sd0, 0);
		send_point(31'sd0, 32'sd0, 1);
		send_point(31'sd10, 32'sd10, 0);
		bursty = 1;

		set_radius(23'd6371000);
		random_points(50);

		drain();
		repeat (300) @(posedge clk);
		if (mismatches == 0 && pending == 0)
			$display("track_haversine_length: match");
		else
			$display("track_haversine_length: mismatch");
		$finish;
	end

	initial begin
		#40000000;
		$display("track_haversine_length: mismatch");
		$finish;
	end

endmodule

// ===== track_haversine_length.f =====
design/hvl_pkg.sv
design/hvl_cordic.sv
design/hvl_isqrt.sv
design/track_haversine_length.sv
sim/track_haversine_checker.sv
sim/testbench.sv
